// ----- sv/tlba_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlba_pkg: shared types and constants for the two-level bitmap ID allocator
// Request codes, result codes, controller/datapath handshake structs and the
// lowest-set-bit helper.
// ----------------------------------------------------------------------------
package tlba_pkg;

    // fixed geometry and field widths
    localparam int WORD_BITS       = 64;
    localparam int BIT_W           = 6;
    localparam int GROUP_WORDS     = 4;
    localparam int LOG_GW          = 2;
    localparam int INDEX_COUNT_DEF = 4096;
    localparam int FUNC_W          = 2;
    localparam int INDEX_W         = 12;
    localparam int LIMIT_W         = 13;
    localparam int STATUS_W        = 3;
    localparam int LIMIT_RESET     = 4096;

    // request opcodes; code 3 is unused and answers out of range
    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC   = 2'd0,
        FUNC_RESERVE = 2'd1,
        FUNC_FREE    = 2'd2
    } func_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NONE_FREE = 3'd1,
        ST_BUSY      = 3'd2,
        ST_FREE      = 3'd3,
        ST_RANGE     = 3'd4
    } status_t;

    // which result the datapath should stage
    typedef enum logic [1:0] {
        RES_GRANT     = 2'd0,
        RES_UPDATE    = 2'd1,
        RES_NONE_FREE = 2'd2,
        RES_RANGE     = 2'd3
    } res_kind_t;

    // controller -> datapath
    typedef struct packed {
        logic      load;
        logic      w_inc;
        logic      w_skip;
        logic      rd_en;
        logic      eval_en;
        logic      mark_set;
        logic      write_en;
        logic      res_set;
        res_kind_t res_kind;
        logic      push;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic op_alloc;
        logic range_bad;
        logic w_end;
        logic grp_marked;
        logic avail_nz;
        logic last_in_group;
        logic id_over;
        logic push_ok;
    } stat_t;

    // position of the lowest set bit, binary search in six halvings
    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] pos;
        logic [31:0]      v32;
        logic [15:0]      v16;
        logic [7:0]       v8;
        logic [3:0]       v4;
        logic [1:0]       v2;
        pos[5] = ~|v[31:0];
        v32    = pos[5] ? v[63:32] : v[31:0];
        pos[4] = ~|v32[15:0];
        v16    = pos[4] ? v32[31:16] : v32[15:0];
        pos[3] = ~|v16[7:0];
        v8     = pos[3] ? v16[15:8] : v16[7:0];
        pos[2] = ~|v8[3:0];
        v4     = pos[2] ? v8[7:4] : v8[3:0];
        pos[1] = ~|v4[1:0];
        v2     = pos[1] ? v4[3:2] : v4[1:0];
        pos[0] = ~v2[0];
        return pos;
    endfunction

endpackage

// ----- sv/two_level_bitmap_id_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_bitmap_id_allocator: lowest-free index allocator
// Busy bitmap in 64-bit words with lazy per-group full marks; allocate,
// reserve and free requests, one result per request.
// ----------------------------------------------------------------------------
//  Channel  Handshake              Payload
//  in       in_valid / in_ready    func[1:0], index[11:0]
//  out      out_valid / out_ready  granted_index[11:0], status[2:0]
//  cfg      cfg_wr_en              cfg_wr_data[12:0] (index limit)
//
//  Reserve and free go through probe with word read, evaluate, update and
//  result. Allocate scans up from word 0, reading and evaluating each word
//  outside a group marked full and skipping marked groups, until it finds a
//  free bit or runs past the last word; the single-port busy-word memory is
//  read once per probed word. No clearing pass: reset clears the word valid
//  bits and group marks at once. A new request is accepted while the previous
//  result waits in the output register; only a second result stalls.
// ----------------------------------------------------------------------------
module two_level_bitmap_id_allocator #(
    parameter int INDEX_COUNT = tlba_pkg::INDEX_COUNT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [tlba_pkg::LIMIT_W-1:0]   cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [tlba_pkg::FUNC_W-1:0]    func,
    input  logic [tlba_pkg::INDEX_W-1:0]   index,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [tlba_pkg::INDEX_W-1:0]   granted_index,
    output logic [tlba_pkg::STATUS_W-1:0]  status
);
    import tlba_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencer
    tlba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath
    tlba_dp #(
        .INDEX_COUNT (INDEX_COUNT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .func          (func),
        .index         (index),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .granted_index (granted_index),
        .status        (status)
    );

endmodule

// ----- sv/tlba_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlba_ctrl: request sequencer
// Walks each request through probe, word read, evaluate and update, and
// holds in the result state until the output register can take the result.
// ----------------------------------------------------------------------------
module tlba_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  tlba_pkg::stat_t stat,
    output tlba_pkg::cmd_t  cmd
);
    import tlba_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PROBE = 5'b00010,
        S_EVAL  = 5'b00100,
        S_DEC   = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (stat.op_alloc)
                begin
                    if (stat.w_end)
                    begin
                        cmd.res_set  = 1'b1;
                        cmd.res_kind = RES_NONE_FREE;
                        state_next   = S_RESP;
                    end
                    else if (stat.grp_marked)
                    begin
                        cmd.w_skip = 1'b1;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        state_next = S_EVAL;
                    end
                end
                else if (stat.range_bad || stat.w_end)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_kind = RES_RANGE;
                    state_next   = S_RESP;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval_en = 1'b1;
                state_next  = S_DEC;
            end
            S_DEC:
            begin
                if (stat.op_alloc)
                begin
                    if (!stat.avail_nz)
                    begin
                        // word full: close the group if this was its last word
                        cmd.mark_set = stat.last_in_group;
                        cmd.w_inc    = 1'b1;
                        state_next   = S_PROBE;
                    end
                    else if (stat.id_over)
                    begin
                        cmd.res_set  = 1'b1;
                        cmd.res_kind = RES_NONE_FREE;
                        state_next   = S_RESP;
                    end
                    else
                    begin
                        cmd.write_en = 1'b1;
                        cmd.res_set  = 1'b1;
                        cmd.res_kind = RES_GRANT;
                        state_next   = S_RESP;
                    end
                end
                else
                begin
                    cmd.write_en = 1'b1;
                    cmd.res_set  = 1'b1;
                    cmd.res_kind = RES_UPDATE;
                    state_next   = S_RESP;
                end
            end
            S_RESP:
            begin
                cmd.push = 1'b1;
                if (stat.push_ok)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    // a word read is always followed by its evaluation
    a_read_then_eval: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |=> (state_reg == S_EVAL))
        else $error("word read not followed by evaluate");

    // every bitmap write comes with a staged result
    a_write_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_en |-> cmd.res_set)
        else $error("bitmap write without result");

    // a delivered result frees the sequencer
    a_push_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && stat.push_ok) |=> (state_reg == S_IDLE))
        else $error("sequencer did not return to idle after result");
`endif

endmodule

// ----- sv/tlba_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlba_dp: allocator datapath
// Busy-word memory with per-word valid bits, group full marks, limit
// register, word scan counter, bit search stage and output register.
// ----------------------------------------------------------------------------
module tlba_dp #(
    parameter int INDEX_COUNT = tlba_pkg::INDEX_COUNT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [tlba_pkg::LIMIT_W-1:0]   cfg_wr_data,
    input  logic [tlba_pkg::FUNC_W-1:0]    func,
    input  logic [tlba_pkg::INDEX_W-1:0]   index,
    input  tlba_pkg::cmd_t                 cmd,
    output tlba_pkg::stat_t                stat,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [tlba_pkg::INDEX_W-1:0]   granted_index,
    output logic [tlba_pkg::STATUS_W-1:0]  status
);
    import tlba_pkg::*;

    localparam int WORD_COUNT  = INDEX_COUNT / WORD_BITS;
    localparam int WADDR_W     = $clog2(WORD_COUNT);
    localparam int WCNT_W      = $clog2(WORD_COUNT + GROUP_WORDS);
    localparam int GROUP_COUNT = (WORD_COUNT + GROUP_WORDS - 1) / GROUP_WORDS;
    localparam int GADDR_W     = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int ID_W        = WADDR_W + BIT_W;
    localparam int CMP_W       = ((ID_W > LIMIT_W) ? ID_W : LIMIT_W) + 1;
    localparam int LIMIT_INIT  = (LIMIT_RESET < INDEX_COUNT) ? LIMIT_RESET : INDEX_COUNT;

    // request registers
    logic [FUNC_W-1:0]      func_reg;
    logic [INDEX_W-1:0]     idx_reg;
    logic [WCNT_W-1:0]      w_cnt_reg;

    // state stores
    logic [WORD_BITS-1:0]   mem [WORD_COUNT];
    logic [WORD_COUNT-1:0]  vld_reg;
    logic [GROUP_COUNT-1:0] marks_reg;
    logic [CMP_W-1:0]       lim_reg;

    // read and search stage
    logic [WORD_BITS-1:0]   rd_data_reg;
    logic                   rd_vld_reg;
    logic [WORD_BITS-1:0]   word_hold_reg;
    logic [BIT_W-1:0]       bit_reg;
    logic                   avail_nz_reg;
    logic                   old_bit_reg;

    // staged and output result
    logic [INDEX_W-1:0]     res_id_reg;
    logic [STATUS_W-1:0]    res_status_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [INDEX_W-1:0]     out_id_reg;
    logic [STATUS_W-1:0]    out_status_reg;

    logic [WADDR_W-1:0]     waddr;
    logic [GADDR_W-1:0]     grp;
    logic [WORD_BITS-1:0]   word_eff;
    logic [WORD_BITS-1:0]   avail;
    logic [WORD_BITS-1:0]   wdata;
    logic [CMP_W-1:0]       id_full;
    logic [CMP_W-1:0]       cfg_ext;
    logic                   push_ok;
    logic                   is_alloc;
    logic                   is_free;

    assign waddr    = w_cnt_reg[WADDR_W-1:0];
    assign grp      = GADDR_W'(w_cnt_reg >> LOG_GW);
    assign word_eff = rd_vld_reg ? rd_data_reg : '0;
    assign avail    = ~word_eff;
    assign id_full  = CMP_W'({waddr, bit_reg});
    assign cfg_ext  = CMP_W'(cfg_wr_data);
    assign push_ok  = !out_valid_reg || out_ready;
    assign is_alloc = (func_reg == FUNC_ALLOC);
    assign is_free  = (func_reg == FUNC_FREE);

    // status to the sequencer
    always_comb
    begin
        stat.op_alloc      = is_alloc;
        stat.range_bad     = !((func_reg == FUNC_RESERVE) || is_free)
                             || (CMP_W'(idx_reg) >= lim_reg);
        stat.w_end         = (w_cnt_reg >= WCNT_W'(WORD_COUNT));
        stat.grp_marked    = marks_reg[grp];
        stat.avail_nz      = avail_nz_reg;
        stat.last_in_group = (w_cnt_reg[LOG_GW-1:0] == '1)
                             || (w_cnt_reg == WCNT_W'(WORD_COUNT - 1));
        stat.id_over       = (id_full >= lim_reg);
        stat.push_ok       = push_ok;
    end

    // updated busy word
    always_comb
    begin
        case (func_reg)
            FUNC_ALLOC:   wdata = word_hold_reg | (WORD_BITS'(1) << bit_reg);
            FUNC_RESERVE: wdata = word_hold_reg | (WORD_BITS'(1) << idx_reg[BIT_W-1:0]);
            FUNC_FREE:    wdata = word_hold_reg & ~(WORD_BITS'(1) << idx_reg[BIT_W-1:0]);
            default:      wdata = word_hold_reg;
        endcase
    end

    // request capture and word scan counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            w_cnt_reg <= (func == FUNC_ALLOC) ? '0 : WCNT_W'(index >> BIT_W);
        end
        else if (cmd.w_skip)
        begin
            w_cnt_reg <= WCNT_W'((w_cnt_reg | WCNT_W'(GROUP_WORDS - 1)) + 1'b1);
        end
        else if (cmd.w_inc)
        begin
            w_cnt_reg <= w_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            idx_reg  <= index;
        end
    end

    // busy word memory, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.write_en)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[waddr];
            rd_vld_reg  <= vld_reg[waddr];
        end
    end

    // word valid bits: an unwritten word reads as all free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (cmd.write_en)
        begin
            vld_reg[waddr] <= 1'b1;
        end
    end

    // group full marks: set by a full scan, cleared by any free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks_reg <= '0;
        end
        else if (cmd.mark_set)
        begin
            marks_reg[grp] <= 1'b1;
        end
        else if (cmd.write_en && is_free)
        begin
            marks_reg[grp] <= 1'b0;
        end
    end

    // limit register, saturated at the pool size
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg <= CMP_W'(LIMIT_INIT);
        end
        else if (cfg_wr_en)
        begin
            lim_reg <= (cfg_ext > CMP_W'(INDEX_COUNT)) ? CMP_W'(INDEX_COUNT) : cfg_ext;
        end
    end

    // free bit search
    always_ff @(posedge clk)
    begin
        if (cmd.eval_en)
        begin
            word_hold_reg <= word_eff;
            bit_reg       <= lowest_set(avail);
            avail_nz_reg  <= |avail;
            old_bit_reg   <= word_eff[idx_reg[BIT_W-1:0]];
        end
    end

    // result staging
    always_ff @(posedge clk)
    begin
        if (cmd.res_set)
        begin
            case (cmd.res_kind)
                RES_GRANT:
                begin
                    res_id_reg     <= id_full[INDEX_W-1:0];
                    res_status_reg <= ST_OK;
                end
                RES_UPDATE:
                begin
                    res_id_reg <= '0;
                    if (is_free)
                    begin
                        res_status_reg <= old_bit_reg ? ST_OK : ST_FREE;
                    end
                    else
                    begin
                        res_status_reg <= old_bit_reg ? ST_BUSY : ST_OK;
                    end
                end
                RES_NONE_FREE:
                begin
                    res_id_reg     <= '0;
                    res_status_reg <= ST_NONE_FREE;
                end
                RES_RANGE:
                begin
                    res_id_reg     <= '0;
                    res_status_reg <= ST_RANGE;
                end
                default:
                begin
                    res_id_reg     <= '0;
                    res_status_reg <= ST_RANGE;
                end
            endcase
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.push && push_ok)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push && push_ok)
        begin
            out_id_reg     <= res_id_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign granted_index = out_id_reg;
    assign status        = out_status_reg;

`ifndef SYNTHESIS
    // a group is only marked full after its last word was found full
    a_mark_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mark_set |-> (!avail_nz_reg && is_alloc))
        else $error("group marked full while a free bit was seen");

    // a grant never reaches the limit
    a_grant_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.res_set && cmd.res_kind == RES_GRANT) |-> (id_full < lim_reg))
        else $error("grant at or above index limit");

    // a waiting result stays put until it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=>
        (out_valid_reg && $stable(out_id_reg) && $stable(out_status_reg)))
        else $error("waiting result changed before it was taken");
`endif

endmodule
